@@ sv/vat_pkg.sv @@
// ----------------------------------------------------------------------------
// vat_pkg: shared types and constants for the voice activity trigger
// Holds register indexes, reset values, stage and intent codes, the words
// passed between the front and back parts, and the tone plan lookup.
// ----------------------------------------------------------------------------
package vat_pkg;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MIN_SAMPLES       = 3'd0,
    REG_FRESHNESS_WINDOW  = 3'd1,
    REG_SPEECH_THRESHOLD  = 3'd2,
    REG_TRIGGER_THRESHOLD = 3'd3,
    REG_TRIGGER_FRAMES    = 3'd4,
    REG_COOLDOWN_WINDOW   = 3'd5
  } vat_reg_t;

  localparam logic [15:0] RST_MIN_SAMPLES       = 16'd160;
  localparam logic [15:0] RST_FRESHNESS_WINDOW  = 16'd250;
  localparam logic [6:0]  RST_SPEECH_THRESHOLD  = 7'd35;
  localparam logic [6:0]  RST_TRIGGER_THRESHOLD = 7'd55;
  localparam logic [7:0]  RST_TRIGGER_FRAMES    = 8'd3;
  localparam logic [15:0] RST_COOLDOWN_WINDOW   = 16'd1500;

  localparam logic [6:0]  ENERGY_MAX  = 7'd100;
  localparam logic [6:0]  FOCUS_BASE  = 7'd45;
  localparam logic [15:0] RUN_MAX     = 16'hFFFF;

  localparam logic [1:0] EMODE_CONSTRAINED = 2'd1;
  localparam logic [1:0] EMODE_CRITICAL    = 2'd2;

  localparam logic [1:0] STAGE_DORMANT   = 2'd0;
  localparam logic [1:0] STAGE_LISTENING = 2'd1;
  localparam logic [1:0] STAGE_CANDIDATE = 2'd2;

  localparam logic [1:0] INTENT_ATTEND   = 2'd0;
  localparam logic [1:0] INTENT_ACK      = 2'd1;
  localparam logic [1:0] INTENT_INSPECT  = 2'd2;
  localparam logic [1:0] INTENT_PRESERVE = 2'd3;

  // What the front part learns about one frame from its inputs alone.
  typedef struct packed {
    logic       usable;
    logic       dormant;
    logic       speech;
    logic       trig_level;
    logic [6:0] focus;
    logic [1:0] intent;
  } vat_cls_t;

  // One result word as it leaves the block.
  typedef struct packed {
    logic       active;
    logic       capture_usable;
    logic [1:0] stage;
    logic [6:0] focus_confidence;
    logic       trigger;
    logic [1:0] intent;
    logic [1:0] cue;
    logic [9:0] tone_hz;
    logic [6:0] tone_ms;
  } vat_res_t;

  function automatic logic [9:0] tone_hz_of(input logic [1:0] intent);
    logic [9:0] hz;
    unique case (intent)
      INTENT_ACK:      hz = 10'd880;
      INTENT_INSPECT:  hz = 10'd620;
      INTENT_PRESERVE: hz = 10'd440;
      default:         hz = 10'd740;
    endcase
    return hz;
  endfunction

  function automatic logic [6:0] tone_ms_of(input logic [1:0] intent);
    logic [6:0] ms;
    unique case (intent)
      INTENT_ACK:      ms = 7'd90;
      INTENT_INSPECT:  ms = 7'd110;
      INTENT_PRESERVE: ms = 7'd80;
      default:         ms = 7'd70;
    endcase
    return ms;
  endfunction

endpackage

@@ sv/vat_front.sv @@
// ----------------------------------------------------------------------------
// vat_front: frame classifier
// Judges the capture, saturates the energy, compares it against the
// thresholds and picks the intent a trigger would carry.
// ----------------------------------------------------------------------------
module vat_front #(
  parameter int TIME_BITS = 32
) (
  input  logic [15:0]          min_samples,
  input  logic [15:0]          freshness_window,
  input  logic [6:0]           speech_threshold,
  input  logic [6:0]           trigger_threshold,
  input  logic [31:0]          now_time,
  input  logic                 capture_ok,
  input  logic [31:0]          capture_time,
  input  logic [15:0]          capture_samples,
  input  logic                 audio_path_ready,
  input  logic [6:0]           frame_energy,
  input  logic                 safe_hold,
  input  logic [1:0]           energy_mode,
  input  logic                 stimulus_seen,
  input  logic                 user_engaged,
  output logic [TIME_BITS-1:0] now_m,
  output vat_pkg::vat_cls_t    cls
);

  logic [TIME_BITS-1:0] cap_m;
  logic [TIME_BITS-1:0] age;
  logic [6:0]           energy_sat;
  logic                 fresh;

  assign now_m = TIME_BITS'(now_time);
  assign cap_m = TIME_BITS'(capture_time);
  assign age   = now_m - cap_m;

  // A capture time of zero means no capture yet; one in the future is stale.
  assign fresh = capture_ok && (cap_m != '0) && (now_m >= cap_m) &&
                 (age <= TIME_BITS'(freshness_window));

  assign energy_sat = (frame_energy > vat_pkg::ENERGY_MAX) ? vat_pkg::ENERGY_MAX
                                                            : frame_energy;

  always_comb begin
    cls.usable     = audio_path_ready && (capture_samples >= min_samples) && fresh;
    cls.dormant    = !cls.usable || safe_hold || (energy_mode == vat_pkg::EMODE_CRITICAL);
    cls.speech     = energy_sat >= speech_threshold;
    cls.trig_level = energy_sat >= trigger_threshold;
    cls.focus      = vat_pkg::FOCUS_BASE + {1'b0, energy_sat[6:1]};
    priority if (energy_mode == vat_pkg::EMODE_CONSTRAINED) begin
      cls.intent = vat_pkg::INTENT_PRESERVE;
    end else if (stimulus_seen) begin
      cls.intent = vat_pkg::INTENT_INSPECT;
    end else if (user_engaged) begin
      cls.intent = vat_pkg::INTENT_ACK;
    end else begin
      cls.intent = vat_pkg::INTENT_ATTEND;
    end
  end

endmodule

@@ sv/vat_fifo.sv @@
// ----------------------------------------------------------------------------
// vat_fifo: short queue between the classifier and the trigger engine
// A small register queue with a look-ahead head word.
// ----------------------------------------------------------------------------
module vat_fifo #(
  parameter int WIDTH = 45,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             head_valid,
  input  logic             head_ready,
  output logic [WIDTH-1:0] head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head_data  = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = head_valid && head_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

@@ sv/vat_back.sv @@
// ----------------------------------------------------------------------------
// vat_back: trigger engine
// Keeps the speech run and the last trigger time, decides the trigger and
// holds the finished result word in an output register.
// ----------------------------------------------------------------------------
module vat_back #(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           trigger_frames,
  input  logic [15:0]          cooldown_window,
  input  logic                 head_valid,
  output logic                 head_ready,
  input  logic [TIME_BITS-1:0] head_now,
  input  vat_pkg::vat_cls_t    head_cls,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vat_pkg::vat_res_t    res
);

  logic [15:0]          speech_run;
  logic [15:0]          speech_run_next;
  logic [TIME_BITS-1:0] last_trigger_time;
  logic                 cool;
  logic                 trig;
  logic                 pop;
  vat_pkg::vat_res_t    res_next;

  assign head_ready = !out_valid || out_ready;
  assign pop        = head_valid && head_ready;

  always_comb begin
    if (head_cls.dormant || !head_cls.speech) begin
      speech_run_next = '0;
    end else if (speech_run != vat_pkg::RUN_MAX) begin
      speech_run_next = speech_run + 16'd1;
    end else begin
      speech_run_next = speech_run;
    end
  end

  // A stored time of zero reads as never triggered.
  assign cool = (last_trigger_time == '0) ||
                ((head_now - last_trigger_time) >= TIME_BITS'(cooldown_window));
  assign trig = !head_cls.dormant && head_cls.trig_level && cool &&
                (speech_run_next >= {8'd0, trigger_frames});

  always_comb begin
    res_next                = '0;
    res_next.capture_usable = head_cls.usable;
    if (!head_cls.dormant) begin
      res_next.active  = head_cls.speech || trig;
      res_next.trigger = trig;
      if (trig) begin
        res_next.stage   = vat_pkg::STAGE_CANDIDATE;
        res_next.intent  = head_cls.intent;
        res_next.cue     = head_cls.intent;
        res_next.tone_hz = vat_pkg::tone_hz_of(head_cls.intent);
        res_next.tone_ms = vat_pkg::tone_ms_of(head_cls.intent);
      end else if (head_cls.speech) begin
        res_next.stage = vat_pkg::STAGE_LISTENING;
      end else begin
        res_next.stage = vat_pkg::STAGE_DORMANT;
      end
      if (head_cls.speech || trig) begin
        res_next.focus_confidence = head_cls.focus;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speech_run        <= '0;
      last_trigger_time <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (pop) begin
        speech_run <= speech_run_next;
        if (trig) begin
          last_trigger_time <= head_now;
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res <= res_next;
    end
  end

endmodule

@@ sv/voice_activity_trigger.sv @@
// ----------------------------------------------------------------------------
// voice_activity_trigger: per-frame voice trigger qualifier
// One input word per audio frame tick; one result word per input word.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_ready) carries one frame word: the
//   current time, the capture status, the frame energy and the context flags.
//   The output channel (out_valid / out_ready) returns one result word per
//   frame, in order: activity, capture usability, stage, focus confidence
//   and, on a trigger, the intent, cue and tone plan.
//   A word accepted at an edge is classified and queued there, and its result
//   is registered when the trigger engine takes it from the queue. Throughput
//   is one word per cycle while out_ready stays high, set by the trigger engine
//   that reads and updates the speech run and last trigger time once per word.
//   Reset clears the speech run and the last trigger time (never triggered),
//   empties the queue, drops out_valid and loads the default thresholds.
//   When the receiver stalls, the result word holds in the output register
//   and the two-word queue keeps taking input; in_ready falls once the queue
//   is full and rises again as soon as a word drains.
//   The registers are written through cfg_we / cfg_index / cfg_data while no
//   word is in flight.
// ----------------------------------------------------------------------------
module voice_activity_trigger #(
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] now_time,
  input  logic        capture_ok,
  input  logic [31:0] capture_time,
  input  logic [15:0] capture_samples,
  input  logic        audio_path_ready,
  input  logic [6:0]  frame_energy,
  input  logic        safe_hold,
  input  logic [1:0]  energy_mode,
  input  logic        stimulus_seen,
  input  logic        user_engaged,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        active,
  output logic        capture_usable,
  output logic [1:0]  stage,
  output logic [6:0]  focus_confidence,
  output logic        trigger,
  output logic [1:0]  intent,
  output logic [1:0]  cue,
  output logic [9:0]  tone_hz,
  output logic [6:0]  tone_ms
);

  // Queue word: the frame time above the classification bits.
  localparam int CLS_W   = $bits(vat_pkg::vat_cls_t);
  localparam int Q_WIDTH = TIME_BITS + CLS_W;
  localparam int Q_DEPTH = 2;

  logic [15:0] min_samples;
  logic [15:0] freshness_window;
  logic [6:0]  speech_threshold;
  logic [6:0]  trigger_threshold;
  logic [7:0]  trigger_frames;
  logic [15:0] cooldown_window;

  logic [TIME_BITS-1:0] front_now;
  vat_pkg::vat_cls_t    front_cls;
  logic                 head_valid;
  logic                 head_ready;
  logic [Q_WIDTH-1:0]   head_data;
  vat_pkg::vat_res_t    res;

  // Configuration registers. Writes must land only while the block is idle;
  // the block does not enforce this. Both parts read them directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_samples       <= vat_pkg::RST_MIN_SAMPLES;
      freshness_window  <= vat_pkg::RST_FRESHNESS_WINDOW;
      speech_threshold  <= vat_pkg::RST_SPEECH_THRESHOLD;
      trigger_threshold <= vat_pkg::RST_TRIGGER_THRESHOLD;
      trigger_frames    <= vat_pkg::RST_TRIGGER_FRAMES;
      cooldown_window   <= vat_pkg::RST_COOLDOWN_WINDOW;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vat_pkg::REG_MIN_SAMPLES:       min_samples       <= cfg_data;
        vat_pkg::REG_FRESHNESS_WINDOW:  freshness_window  <= cfg_data;
        vat_pkg::REG_SPEECH_THRESHOLD:  speech_threshold  <= cfg_data[6:0];
        vat_pkg::REG_TRIGGER_THRESHOLD: trigger_threshold <= cfg_data[6:0];
        vat_pkg::REG_TRIGGER_FRAMES:    trigger_frames    <= cfg_data[7:0];
        vat_pkg::REG_COOLDOWN_WINDOW:   cooldown_window   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front part: classifies each frame from its own fields.
  vat_front #(
    .TIME_BITS(TIME_BITS)
  ) u_front (
    .min_samples      (min_samples),
    .freshness_window (freshness_window),
    .speech_threshold (speech_threshold),
    .trigger_threshold(trigger_threshold),
    .now_time         (now_time),
    .capture_ok       (capture_ok),
    .capture_time     (capture_time),
    .capture_samples  (capture_samples),
    .audio_path_ready (audio_path_ready),
    .frame_energy     (frame_energy),
    .safe_hold        (safe_hold),
    .energy_mode      (energy_mode),
    .stimulus_seen    (stimulus_seen),
    .user_engaged     (user_engaged),
    .now_m            (front_now),
    .cls              (front_cls)
  );

  // Queue between the classifier and the trigger engine.
  vat_fifo #(
    .WIDTH(Q_WIDTH),
    .DEPTH(Q_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(in_valid),
    .push_ready(in_ready),
    .push_data ({front_now, front_cls}),
    .head_valid(head_valid),
    .head_ready(head_ready),
    .head_data (head_data)
  );

  // Back part: run counting, cooldown and the result register.
  vat_back #(
    .TIME_BITS(TIME_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .trigger_frames (trigger_frames),
    .cooldown_window(cooldown_window),
    .head_valid     (head_valid),
    .head_ready     (head_ready),
    .head_now       (head_data[Q_WIDTH-1:CLS_W]),
    .head_cls       (vat_pkg::vat_cls_t'(head_data[CLS_W-1:0])),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .res            (res)
  );

  assign active           = res.active;
  assign capture_usable   = res.capture_usable;
  assign stage            = res.stage;
  assign focus_confidence = res.focus_confidence;
  assign trigger          = res.trigger;
  assign intent           = res.intent;
  assign cue              = res.cue;
  assign tone_hz          = res.tone_hz;
  assign tone_ms          = res.tone_ms;

endmodule
